[rtl/pjrm_pkg.sv]
// Package for the packet jitter ring manager: sizes, codes, payload structs
// and the sequencer state type. No dependencies.
`default_nettype none
package pjrm_pkg;

  localparam int unsigned RingSlots  = 512;
  localparam int unsigned SlotW      = $clog2(RingSlots);
  localparam int unsigned MaxPayload = 2048;
  localparam int unsigned CfgW       = 12;
  localparam int unsigned NumRegs    = 4;
  localparam int unsigned AddrW      = 4;

  localparam logic [CfgW-1:0] FramesRst  = 12'd352;
  localparam logic [CfgW-1:0] DistRst    = 12'd128;
  localparam logic [CfgW-1:0] MinRunRst  = 12'd8;
  localparam logic [CfgW-1:0] PrerollRst = 12'd16;

  typedef enum logic [1:0] {
    RegFrames  = 2'd0,
    RegDist    = 2'd1,
    RegMinRun  = 2'd2,
    RegPreroll = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    CmdInsert = 3'd0,
    CmdPop    = 3'd1,
    CmdFlush  = 3'd2,
    CmdHole   = 3'd3,
    CmdResync = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    StStored    = 4'd0,
    StIgnored   = 4'd1,
    StRejected  = 4'd2,
    StData      = 4'd3,
    StConcealed = 4'd4,
    StStall     = 4'd5,
    StHole      = 4'd6,
    StNoHole    = 4'd7,
    StResynced  = 4'd8,
    StNoResync  = 4'd9,
    StFlushed   = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    CondEmpty     = 2'd0,
    CondReceived  = 2'd1,
    CondConcealed = 2'd2,
    CondConsumed  = 2'd3
  } cond_e;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SRead,
    SExec,
    SHoleRd,
    SHoleChk,
    SMaxRd,
    SMaxChk,
    SRunRd,
    SRunChk,
    SJump,
    SOut
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] seq_in;
    logic [31:0] stamp_in;
    logic [15:0] length_in;
    logic        deadline_over;
  } in_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [31:0]      seq_first;
    logic [31:0]      seq_last;
    logic [31:0]      stamp_out;
    logic [11:0]      frames_out;
    logic [15:0]      length_out;
    logic [SlotW-1:0] slot_index;
    logic [31:0]      skipped;
  } out_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [31:0] seq;
    logic [1:0]  cond;
    logic [31:0] stamp;
    logic [15:0] len;
  } slot_t;

endpackage
`default_nettype wire

[rtl/packet_jitter_ring_manager.sv]
// Top level of the packet jitter ring manager: APB registers, slot memory and
// the command sequencer. Depends on pjrm_pkg.
//
// One command at a time. After reset a clearing pass writes generation zero to
// all 512 slots before the first transaction is taken. Insert, pop, flush and
// unknown commands pass through the read, execute and output states; the result
// is then held in its own output register, so the next transaction can be taken
// while it waits. A resend search reads one slot at a time from the cursor, with
// a read state and a check state per slot, over at most all 512 slots. A resync
// scans all 512 slots for the newest received packet and then walks the run back
// one slot at a time in the same way, through the single-port slot memory.
`default_nettype none
module packet_jitter_ring_manager import pjrm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o
);

  localparam logic [SlotW:0] SlotCnt = (SlotW+1)'(RingSlots);

  logic [CfgW-1:0] frames_q, dist_q, minrun_q, preroll_q;
  logic [1:0] ridx;
  assign ridx   = paddr[3:2];
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(ridx))
      RegFrames:  prdata = {20'd0, frames_q};
      RegDist:    prdata = {20'd0, dist_q};
      RegMinRun:  prdata = {20'd0, minrun_q};
      RegPreroll: prdata = {20'd0, preroll_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q  <= FramesRst;
      dist_q    <= DistRst;
      minrun_q  <= MinRunRst;
      preroll_q <= PrerollRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(ridx))
        RegFrames:  frames_q  <= pwdata[CfgW-1:0];
        RegDist:    dist_q    <= pwdata[CfgW-1:0];
        RegMinRun:  minrun_q  <= pwdata[CfgW-1:0];
        RegPreroll: preroll_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // slot memory
  slot_t            mem [RingSlots];
  slot_t            rd_q;
  logic [SlotW-1:0] addr;
  logic             we;
  slot_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  state_e           state_q, state_d;
  in_t              in_q, in_d;
  out_t             res_q, res_d;
  out_t             out_q, out_d;
  logic [31:0]      cursor_q, cursor_d, bound_q, bound_d, gen_q, gen_d;
  logic [SlotW:0]   cnt_q, cnt_d;
  logic [31:0]      e_q, e_d, start_q, start_d, hi_q, hi_d;
  logic             flag_q, flag_d;
  logic             ovalid_q, ovalid_d;

  logic [31:0] rs_m1, tgt;
  logic        hit_rcv;
  assign hit_rcv = rd_q.gen == gen_q && rd_q.cond == CondReceived;
  assign rs_m1   = e_q - 32'd1;

  always_comb begin
    if (e_q > {20'd0, preroll_q}) tgt = e_q - {20'd0, preroll_q};
    else tgt = e_q;
    if (tgt < cursor_q) tgt = cursor_q;
  end

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d  = state_q;
    in_d     = in_q;
    res_d    = res_q;
    out_d    = out_q;
    cursor_d = cursor_q;
    bound_d  = bound_q;
    gen_d    = gen_q;
    cnt_d    = cnt_q;
    e_d      = e_q;
    start_d  = start_q;
    hi_d     = hi_q;
    flag_d   = flag_q;
    ovalid_d = ovalid_q;
    addr     = in_q.seq_in[SlotW-1:0];
    we       = 1'b0;
    wdata    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      SClear: begin
        addr = cnt_q[SlotW-1:0];
        we   = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SlotCnt - 1'b1) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          res_d   = '0;
          res_d.status = StIgnored;
          state_d = SRead;
        end
      end
      SRead: begin
        addr = (in_q.cmd == CmdPop) ? cursor_q[SlotW-1:0] : in_q.seq_in[SlotW-1:0];
        state_d = SExec;
      end
      SExec: begin
        state_d = SOut;
        priority case (in_q.cmd)
          CmdInsert: begin
            addr = in_q.seq_in[SlotW-1:0];
            if (in_q.length_in > 16'(MaxPayload) || in_q.seq_in < bound_q)
              res_d.status = StRejected;
            else if (in_q.seq_in < cursor_q || (hit_rcv && rd_q.seq == in_q.seq_in))
              res_d.status = StIgnored;
            else begin
              we = 1'b1;
              wdata = '{gen: gen_q, seq: in_q.seq_in, cond: CondReceived,
                        stamp: in_q.stamp_in, len: in_q.length_in};
              res_d.status = StStored;
              res_d.slot_index = in_q.seq_in[SlotW-1:0];
            end
          end
          CmdPop: begin
            addr = cursor_q[SlotW-1:0];
            res_d.seq_first = cursor_q;
            if (hit_rcv && rd_q.seq == cursor_q) begin
              we = 1'b1;
              wdata = rd_q;
              wdata.cond = CondConsumed;
              res_d.status = StData;
              res_d.stamp_out = rd_q.stamp;
              res_d.frames_out = frames_q;
              res_d.length_out = rd_q.len;
              res_d.slot_index = cursor_q[SlotW-1:0];
              cursor_d = cursor_q + 32'd1;
            end else if (in_q.deadline_over) begin
              we = 1'b1;
              wdata = rd_q;
              wdata.gen = gen_q;
              wdata.seq = cursor_q;
              wdata.cond = CondConcealed;
              res_d.status = StConcealed;
              res_d.frames_out = frames_q;
              res_d.slot_index = cursor_q[SlotW-1:0];
              cursor_d = cursor_q + 32'd1;
            end else res_d.status = StStall;
          end
          CmdFlush: begin
            gen_d = gen_q + 32'd1;
            cursor_d = in_q.seq_in;
            bound_d = in_q.seq_in;
            res_d.status = StFlushed;
          end
          CmdHole: begin
            res_d.status = StNoHole;
            e_d = cursor_q;
            cnt_d = '0;
            flag_d = 1'b0;
            state_d = SHoleRd;
          end
          CmdResync: begin
            res_d.status = StNoResync;
            cnt_d = '0;
            flag_d = 1'b0;
            hi_d = '0;
            state_d = SMaxRd;
          end
          default: ;
        endcase
      end
      SHoleRd: begin
        addr = e_q[SlotW-1:0];
        state_d = SHoleChk;
      end
      SHoleChk: begin
        addr = e_q[SlotW-1:0];
        state_d = SHoleRd;
        if (!(rd_q.gen == gen_q && rd_q.seq == e_q && rd_q.cond != CondEmpty)) begin
          if (!flag_q) begin
            start_d = e_q;
            flag_d = 1'b1;
          end
        end else if (flag_q) begin
          res_d.status = StHole;
          res_d.seq_first = start_q;
          res_d.seq_last = rs_m1;
          state_d = SOut;
        end
        e_d = e_q + 32'd1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SlotCnt - 1'b1) state_d = SOut;
      end
      SMaxRd: begin
        addr = cnt_q[SlotW-1:0];
        state_d = SMaxChk;
      end
      SMaxChk: begin
        addr = cnt_q[SlotW-1:0];
        state_d = SMaxRd;
        if (hit_rcv && rd_q.seq >= cursor_q && (!flag_q || rd_q.seq > hi_q)) begin
          hi_d = rd_q.seq;
          flag_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SlotCnt - 1'b1) begin
          state_d = SOut;
          if (flag_d && {1'b0, hi_d} >= {1'b0, cursor_q} + {21'd0, dist_q}) begin
            e_d = hi_d;
            state_d = SRunRd;
          end
        end
      end
      SRunRd: begin
        addr = rs_m1[SlotW-1:0];
        if (e_q > cursor_q) state_d = SRunChk;
        else state_d = SJump;
      end
      SRunChk: begin
        addr = rs_m1[SlotW-1:0];
        if (hit_rcv && rd_q.seq == rs_m1) begin
          e_d = rs_m1;
          state_d = SRunRd;
        end else state_d = SJump;
      end
      SJump: begin
        state_d = SOut;
        if ({1'b0, hi_q - e_q} + 33'd1 >= {21'd0, minrun_q}) begin
          res_d.status = StResynced;
          res_d.skipped = tgt - cursor_q;
          cursor_d = tgt;
        end
      end
      SOut: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          out_d = res_q;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      cursor_q <= '0;
      bound_q  <= '0;
      gen_q    <= 32'd1;
      cnt_q    <= '0;
      flag_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      bound_q  <= bound_d;
      gen_q    <= gen_d;
      cnt_q    <= cnt_d;
      flag_q   <= flag_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    res_q   <= res_d;
    out_q   <= out_d;
    e_q     <= e_d;
    start_q <= start_d;
    hi_q    <= hi_d;
  end

endmodule
`default_nettype wire
